// File: hw/rtl/cabn_pkg.sv
// ----------------------------------------------------------------------------
// cabn_pkg: shared constants for class-aware box suppression
// Widths, capacity and reset threshold used across the block.
// ----------------------------------------------------------------------------
package cabn_pkg;
	localparam int MaxBoxes   = 64;
	localparam int IdxW       = 6;
	localparam int CntW       = 7;
	localparam int ClassBits  = 8;
	localparam int CoordW     = 16;
	localparam logic [15:0] ThreshReset = 16'd29491;
endpackage

// File: hw/rtl/class_aware_box_nms.sv
// ----------------------------------------------------------------------------
// class_aware_box_nms: per-class greedy non-maximum suppression
// Loads a set of boxes, ranks them by score, keeps boxes greedily and
// streams the arrival indices of the kept boxes in rank order.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_axis  | in  | tvalid/tready      | tdata box fields, tlast = set_end
// m_axis  | out | tvalid/tready      | tdata kept_index, tuser overflow, tlast
// cfg     | in  | cfg_valid/cfg_ready| overlap_threshold
// Loading accepts one box per cycle. After the closing box an insertion sort
// ranks the boxes, reading scores through the score memory; each kept box then
// sweeps all later-ranked boxes through the shared multiplier. A kept index is
// held until the next kept box is found, so the last one carries tlast; output
// stalls hold the walk. Asynchronous reset; no clearing pass. Input is stalled
// while a set is sorted, suppressed or emitted.
// ----------------------------------------------------------------------------
module class_aware_box_nms (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// left[15:0] top[31:16] right[47:32] bottom[63:48] score[79:64] class[87:80]
	input  logic [87:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kept_index[5:0], zero fill
	output logic [7:0]  m_axis_tdata,
	// overflow_seen[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	localparam int IW = cabn_pkg::IdxW;
	localparam int CW = cabn_pkg::CntW;
	localparam int MaxB = cabn_pkg::MaxBoxes;
	localparam int ClW = cabn_pkg::ClassBits;

	localparam logic [3:0] StLoad = 4'd0, StSortRd = 4'd1, StSortCmp = 4'd2,
		StOutRd = 4'd3, StOutChk = 4'd4, StEmit = 4'd5, StPairRd = 4'd6,
		StPairGeo = 4'd7, StPairMul = 4'd8, StPairCmp = 4'd9, StDone = 4'd10;

	logic [3:0] state_q;
	logic [15:0] thresh_q;
	logic [CW-1:0] count_q;
	logic ovf_q;
	logic [MaxB-1:0] supp_q;

	logic [63:0] corner_mem [MaxB];
	logic [15:0] score_mem [MaxB];
	logic [ClW-1:0] class_mem [MaxB];
	logic [IW-1:0] rank_mem [MaxB];

	// sort: insertion by pointers; i = item, j = slot
	logic [CW-1:0] i_q, j_q;
	logic [IW-1:0] rk_q;          // rank_mem[j-1] read data
	logic [15:0] sc_prev_q, sc_cur_q;

	logic [IW-1:0] a_q, b_q;
	logic [63:0] ca_q, cb_q;
	logic [ClW-1:0] cla_q, clb_q;
	logic [15:0] iw_q, ih_q;
	logic [32:0] area_a_q;
	logic [16:0] aw_q, ah_q, bw_q, bh_q;
	logic [31:0] inter_q;
	logic [33:0] uni_q;
	logic [1:0] mul_ph_q;
	logic [49:0] prod_q;
	logic pend_q;
	logic [IW-1:0] pend_idx_q;

	logic load_fire;
	assign s_axis_tready = (state_q == StLoad);
	assign load_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = (state_q == StLoad);

	function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
		span16 = (hi > lo) ? hi - lo : 16'd0;
	endfunction

	logic [15:0] ix1, iy1, ix2, iy2;
	always_comb begin
		ix1 = (ca_q[15:0]  > cb_q[15:0])  ? ca_q[15:0]  : cb_q[15:0];
		iy1 = (ca_q[31:16] > cb_q[31:16]) ? ca_q[31:16] : cb_q[31:16];
		ix2 = (ca_q[47:32] < cb_q[47:32]) ? ca_q[47:32] : cb_q[47:32];
		iy2 = (ca_q[63:48] < cb_q[63:48]) ? ca_q[63:48] : cb_q[63:48];
	end

	// memories
	logic rank_we;
	logic [IW-1:0] rank_wa, rank_wd, rank_ra;
	logic [IW-1:0] rank_rd_q;
	always_ff @(posedge clk) begin
		if (load_fire && count_q < CW'(MaxB)) begin
			corner_mem[count_q[IW-1:0]] <= s_axis_tdata[63:0];
			score_mem[count_q[IW-1:0]]  <= s_axis_tdata[79:64];
			class_mem[count_q[IW-1:0]]  <= s_axis_tdata[80 +: ClW];
		end
		if (rank_we) rank_mem[rank_wa] <= rank_wd;
		rank_rd_q <= rank_mem[rank_ra];
	end

	logic [CW-1:0] n_q, oi_q, oj_q;

	always_comb begin
		rank_we = 1'b0;
		rank_wa = j_q[IW-1:0];
		rank_wd = i_q[IW-1:0];
		rank_ra = IW'(j_q - CW'(1));
		unique case (state_q)
			StSortCmp: begin
				rank_we = 1'b1;
				if (j_q != '0 && sc_prev_q < sc_cur_q) rank_wd = rk_q;
			end
			StOutRd:  rank_ra = oi_q[IW-1:0];
			StPairRd: rank_ra = oj_q[IW-1:0];
			default: ;
		endcase
	end

	// score/class/corner reads registered by stage
	logic [15:0] sc_rd_q;
	logic [63:0] cr_rd_q;
	logic [ClW-1:0] cl_rd_q;
	logic [IW-1:0] scidx;
	assign scidx = rank_rd_q;
	always_ff @(posedge clk) begin
		sc_rd_q <= score_mem[scidx];
		cr_rd_q <= corner_mem[scidx];
		cl_rd_q <= class_mem[scidx];
	end

	logic [1:0] sub_q;
	logic [31:0] mul_a;
	logic [33:0] mul_b;
	logic [65:0] mul_p;
	assign mul_p = mul_a * mul_b;
	always_comb begin
		unique case (mul_ph_q)
			2'd0: begin mul_a = {16'd0, iw_q}; mul_b = {18'd0, ih_q}; end
			2'd1: begin mul_a = {15'd0, aw_q}; mul_b = {17'd0, ah_q}; end
			2'd2: begin mul_a = {15'd0, bw_q}; mul_b = {17'd0, bh_q}; end
			default: begin mul_a = {16'd0, thresh_q}; mul_b = uni_q; end
		endcase
	end

	// output register: load a held index when the slot frees up
	logic out_free, out_load;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign out_load = pend_q && out_free && (state_q == StEmit || state_q == StDone);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tuser <= 1'b0;
			m_axis_tlast <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
			m_axis_tdata <= {2'b00, pend_idx_q};
			m_axis_tuser <= ovf_q;
			m_axis_tlast <= (state_q == StDone);
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	logic [32:0] area_b_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			thresh_q <= cabn_pkg::ThreshReset;
			count_q <= '0;
			ovf_q <= 1'b0;
			supp_q <= '0;
			sub_q <= '0;
			mul_ph_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) thresh_q <= cfg_data;
			unique case (state_q)
				StLoad: if (load_fire) begin
					if (count_q < CW'(MaxB)) count_q <= count_q + CW'(1);
					else ovf_q <= 1'b1;
					if (s_axis_tlast) begin
						n_q <= (count_q < CW'(MaxB)) ? count_q + CW'(1) : count_q;
						i_q <= '0; j_q <= '0; sub_q <= '0;
						state_q <= StSortRd;
					end
				end
				StSortRd: begin
					// steps by sub_q, in order: rank read addr j-1 issued; score read; use
					if (sub_q == 2'd0) begin
						sc_cur_q <= score_mem[i_q[IW-1:0]];
						sub_q <= 2'd1;
					end else if (sub_q == 2'd1) begin
						rk_q <= rank_rd_q;
						sub_q <= 2'd2;
					end else begin
						sc_prev_q <= sc_rd_q;
						sub_q <= '0;
						state_q <= StSortCmp;
					end
				end
				StSortCmp: begin
					if (j_q != '0 && sc_prev_q < sc_cur_q) begin
						j_q <= j_q - CW'(1);
						state_q <= StSortRd;
					end else if (i_q + CW'(1) == n_q) begin
						oi_q <= '0; state_q <= StOutRd; sub_q <= '0;
					end else begin
						i_q <= i_q + CW'(1); j_q <= i_q + CW'(1);
						state_q <= StSortRd;
					end
				end
				StOutRd: begin
					if (sub_q == 2'd1) begin
						a_q <= rank_rd_q;
						sub_q <= '0;
						state_q <= StOutChk;
					end else begin
						sub_q <= 2'd1;
					end
				end
				StOutChk: begin
					ca_q <= cr_rd_q; cla_q <= cl_rd_q;
					if (supp_q[a_q]) begin
						if (oi_q + CW'(1) == n_q) state_q <= StDone;
						else begin oi_q <= oi_q + CW'(1); state_q <= StOutRd; end
					end else begin
						oj_q <= oi_q + CW'(1);
						state_q <= StEmit;
					end
				end
				StEmit: begin
					// send the previously held index, then hold this one
					if (!pend_q || out_free) begin
						pend_q <= 1'b1;
						pend_idx_q <= a_q;
						if (oj_q == n_q) state_q <= StDone;
						else state_q <= StPairRd;
					end
				end
				StPairRd: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else if (sub_q == 2'd1) begin
						b_q <= rank_rd_q;
						sub_q <= 2'd2;
					end else begin
						cb_q <= cr_rd_q; clb_q <= cl_rd_q; sub_q <= '0;
						state_q <= StPairGeo;
					end
				end
				StPairGeo: begin
					iw_q <= span16(ix1, ix2); ih_q <= span16(iy1, iy2);
					aw_q <= {1'b0, span16(ca_q[15:0], ca_q[47:32])};
					ah_q <= {1'b0, span16(ca_q[31:16], ca_q[63:48])};
					bw_q <= {1'b0, span16(cb_q[15:0], cb_q[47:32])};
					bh_q <= {1'b0, span16(cb_q[31:16], cb_q[63:48])};
					mul_ph_q <= 2'd0;
					state_q <= StPairMul;
				end
				StPairMul: begin
					mul_ph_q <= mul_ph_q + 2'd1;
					unique case (mul_ph_q)
						2'd0: inter_q <= mul_p[31:0];
						2'd1: area_a_q <= {1'b0, mul_p[31:0]};
						2'd2: area_b_q <= {1'b0, mul_p[31:0]};
						default: ;
					endcase
					if (mul_ph_q == 2'd2) state_q <= StPairCmp;
				end
				StPairCmp: begin
					if (mul_ph_q == 2'd3 && sub_q == 2'd0) begin
						uni_q <= 34'(area_a_q) + 34'(area_b_q) - 34'(inter_q);
						sub_q <= 2'd1;
					end else if (sub_q == 2'd1) begin
						prod_q <= mul_p[49:0];
						sub_q <= 2'd2;
					end else begin
						sub_q <= '0;
						mul_ph_q <= '0;
						if (!supp_q[b_q] && cla_q == clb_q && uni_q != '0
							&& {2'd0, inter_q, 16'd0} > prod_q)
							supp_q[b_q] <= 1'b1;
						if (oj_q + CW'(1) == n_q) begin
							oi_q <= oi_q + CW'(1);
							state_q <= StOutRd;
						end else begin
							oj_q <= oj_q + CW'(1);
							state_q <= StPairRd;
						end
					end
				end
				StDone: begin
					// final held index leaves with tlast; clear the set
					if (out_free) begin
						pend_q <= 1'b0;
						count_q <= '0; ovf_q <= 1'b0; supp_q <= '0;
						state_q <= StLoad;
					end
				end
				default: state_q <= StLoad;
			endcase
		end
	end
endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: class-aware box suppression testbench
// Streams sets of boxes into the block, predicts the kept indices with a
// local greedy per-class suppression model and checks every output transfer.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CycleLimit = 3000000;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] right;
		logic [15:0] bottom;
		logic [15:0] score;
		logic [7:0]  cls;
		logic        last;
	} box_t;

	typedef struct packed {
		logic [5:0] idx;
		logic       run_end;
		logic       ovf;
	} kept_t;

	class nms_scoreboard;
		box_t        set_boxes[$];
		logic        ovf;
		logic [15:0] thresh;
		kept_t       kept_q[$];
		int          errors;

		function new();
			ovf = 0;
			thresh = cabn_pkg::ThreshReset;
			errors = 0;
		endfunction

		function logic [63:0] spn(logic [15:0] lo, logic [15:0] hi);
			return (hi > lo) ? 64'(hi - lo) : 64'd0;
		endfunction

		function bit too_close(box_t a, box_t b);
			logic [15:0] ix1, iy1, ix2, iy2;
			logic [63:0] inter, ua, ub, un;
			ix1 = (a.left > b.left) ? a.left : b.left;
			iy1 = (a.top > b.top) ? a.top : b.top;
			ix2 = (a.right < b.right) ? a.right : b.right;
			iy2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
			inter = spn(ix1, ix2) * spn(iy1, iy2);
			ua = spn(a.left, a.right) * spn(a.top, a.bottom);
			ub = spn(b.left, b.right) * spn(b.top, b.bottom);
			un = ua + ub - inter;
			if (un == 0)
				return 0;
			return (inter << 16) > (64'(thresh) * un);
		endfunction

		function void note_box(box_t b);
			int rank[$];
			bit sup[64];
			int n, j, cur;
			kept_t k;
			if (set_boxes.size() < cabn_pkg::MaxBoxes)
				set_boxes.insert(set_boxes.size(), b);
			else
				ovf = 1;
			if (!b.last)
				return;
			n = set_boxes.size();
			// stable rank: descending score, lower arrival first on ties
			for (int i = 0; i < n; i++) begin
				j = 0;
				while (j < rank.size() && set_boxes[rank[j]].score >= set_boxes[i].score)
					j++;
				rank.insert(j, i);
			end
			for (int i = 0; i < 64; i++)
				sup[i] = 0;
			for (int i = 0; i < n; i++) begin
				cur = rank[i];
				if (sup[cur])
					continue;
				k.idx = 6'(cur);
				k.run_end = 1'b0;
				k.ovf = ovf;
				kept_q.insert(kept_q.size(), k);
				for (int m = i + 1; m < n; m++) begin
					if (sup[rank[m]] || set_boxes[cur].cls != set_boxes[rank[m]].cls)
						continue;
					if (too_close(set_boxes[cur], set_boxes[rank[m]]))
						sup[rank[m]] = 1;
				end
			end
			kept_q[kept_q.size() - 1].run_end = 1;
			set_boxes.delete();
			ovf = 0;
		endfunction

		function void check_kept(kept_t got);
			kept_t exp;
			if (kept_q.size() == 0) begin
				$display("%0t: unexpected result idx=%0d end=%0d ovf=%0d", $time,
					got.idx, got.run_end, got.ovf);
				errors++;
				return;
			end
			exp = kept_q.pop_front();
			if (got.idx !== exp.idx) begin
				$display("%0t: kept_index expected %0d actual %0d", $time, exp.idx, got.idx);
				errors++;
			end
			if (got.run_end !== exp.run_end) begin
				$display("%0t: run_end expected %0d actual %0d", $time,
					exp.run_end, got.run_end);
				errors++;
			end
			if (got.ovf !== exp.ovf) begin
				$display("%0t: overflow_seen expected %0d actual %0d", $time, exp.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	nms_scoreboard sb;
	int cycles;
	bit sink_idle_ok;

	class_aware_box_nms i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// output side: random stall, check each transfer
	initial begin
		int g;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_kept('{idx: m_axis_tdata[5:0], run_end: m_axis_tlast,
					ovf: m_axis_tuser});
			if (sink_idle_ok && $urandom_range(0, 3) == 0) begin
				g = gap_len();
				m_axis_tready <= 0;
				repeat (g) begin
					@(posedge clk);
				end
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// valid stays high into the next box when there is no gap
	task automatic send_box(box_t b);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_axis_tdata <= {b.cls, b.score, b.bottom, b.right, b.top, b.left};
		s_axis_tlast <= b.last;
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_box(b);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.kept_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] val);
		drain();
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.thresh = val;
	endtask

	function automatic box_t rand_box(int base_x, int base_y, int spread, int ncls);
		box_t b;
		b.left = 16'(base_x + $urandom_range(0, spread));
		b.top = 16'(base_y + $urandom_range(0, spread));
		b.right = 16'(b.left + $urandom_range(0, spread * 2));
		b.bottom = 16'(b.top + $urandom_range(0, spread * 2));
		b.score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 16384)
			: 16'($urandom);
		b.cls = 8'($urandom_range(0, ncls - 1));
		if ($urandom_range(0, 9) == 0)
			b.cls = 8'($urandom);
		b.last = 0;
		return b;
	endfunction

	task automatic send_random_set(int n);
		box_t b;
		int bx, by;
		bx = $urandom_range(0, 60000);
		by = $urandom_range(0, 60000);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				b = rand_box($urandom_range(0, 32767), $urandom_range(0, 32767), 16000, 4);
			else
				b = rand_box(bx % 65000, by % 65000, 200, 3);
			b.last = (i == n - 1);
			send_box(b);
		end
	endtask

	initial begin
		int sent;
		sb = new();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		cfg_valid = 0;
		cfg_data = '0;
		sink_idle_ok = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		sink_idle_ok = 1;

		// single box, extreme fields
		send_box('{left: 16'hFFFF, top: 16'hFFFF, right: 16'hFFFF, bottom: 16'hFFFF,
			score: 16'hFFFF, cls: 8'hFF, last: 1'b1});
		// identical boxes, equal scores: tie goes to lower arrival index
		for (int i = 0; i < 3; i++)
			send_box('{left: 16'd0, top: 16'd0, right: 16'd100, bottom: 16'd100,
				score: 16'd500, cls: 8'd1, last: 1'(i == 2)});
		// same place, different classes: no cross-class suppression
		send_box('{left: 16'd0, top: 16'd0, right: 16'hFFFF, bottom: 16'hFFFF,
			score: 16'd0, cls: 8'd0, last: 1'b0});
		send_box('{left: 16'd0, top: 16'd0, right: 16'hFFFF, bottom: 16'hFFFF,
			score: 16'd9, cls: 8'hAA, last: 1'b0});
		// degenerate boxes: zero union never suppresses
		send_box('{left: 16'd50, top: 16'd50, right: 16'd50, bottom: 16'd80,
			score: 16'd7, cls: 8'h55, last: 1'b0});
		send_box('{left: 16'd60, top: 16'd60, right: 16'd10, bottom: 16'd10,
			score: 16'd7, cls: 8'h55, last: 1'b1});
		// overlap near the threshold
		send_box('{left: 16'd0, top: 16'd0, right: 16'd100, bottom: 16'd100,
			score: 16'd900, cls: 8'd2, last: 1'b0});
		send_box('{left: 16'd0, top: 16'd0, right: 16'd100, bottom: 16'd45,
			score: 16'd800, cls: 8'd2, last: 1'b0});
		send_box('{left: 16'd0, top: 16'd0, right: 16'd100, bottom: 16'd46,
			score: 16'd700, cls: 8'd2, last: 1'b1});

		// hold input until every result is back
		drain();

		write_threshold(16'd0);
		send_random_set(6);
		write_threshold(16'hFFFF);
		send_random_set(6);
		// overflow: capacity plus two, closing box dropped
		write_threshold(16'd32768);
		send_random_set(cabn_pkg::MaxBoxes + 2);
		sent = 0;
		while (sent < 85) begin
			int n;
			if ($urandom_range(0, 4) == 0)
				write_threshold(16'($urandom));
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, cabn_pkg::MaxBoxes)
				: $urandom_range(1, 10);
			send_random_set(n);
			sent += n;
		end
		write_threshold(cabn_pkg::ThreshReset);
		send_random_set(5);

		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.kept_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
